// ===== sv/cadf_pkg.sv =====
// Shared types and constants of the allow/deny prefix filter.
// Used by every module of the block; it depends on nothing else.
package cadf_pkg;

    // Rule storage geometry
    localparam int RULES_PER_LIST = 16;
    localparam int TOTAL_RULES    = 2 * RULES_PER_LIST;
    localparam int ADDR_W         = $clog2(TOTAL_RULES);
    localparam int WALK_W         = ADDR_W + 1;

    // Field widths
    localparam int CNT_W    = 5;
    localparam int SLOT_W   = 4;
    localparam int FAM_W    = 2;
    localparam int PREFIX_W = 8;
    localparam int WORD_W   = 64;

    // Input beat layout in s_tdata, lowest field first
    localparam int LIST_LSB   = 0;
    localparam int SLOT_LSB   = LIST_LSB + 1;
    localparam int FAM_LSB    = SLOT_LSB + SLOT_W;
    localparam int PREFIX_LSB = FAM_LSB + FAM_W;
    localparam int HI_LSB     = PREFIX_LSB + PREFIX_W;
    localparam int LO_LSB     = HI_LSB + WORD_W;
    localparam int S_TDATA_W  = ((LO_LSB + WORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = 8;

    // Prefix limits per family
    localparam int V4_PREFIX_MAX = 32;
    localparam int V6_PREFIX_MAX = 128;

    // Codes
    localparam logic [FAM_W-1:0] FAM_V4 = 2'd0;
    localparam logic [FAM_W-1:0] FAM_V6 = 2'd1;
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_CHECK = 1'b1;
    localparam logic CFG_ALLOW_COUNT = 1'b0;
    localparam logic CFG_DENY_COUNT  = 1'b1;

    // Command queue
    localparam int CMDQ_DEPTH = 2;
    localparam int CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_NULL,
        KIND_WRITE,
        KIND_CHECK
    } cmd_kind_t;

    // Classified command from the front end to the back end
    typedef struct packed {
        cmd_kind_t             kind;
        logic                  rule_ok;
        logic                  fam_bit;
        logic [PREFIX_W-1:0]   prefix;
        logic [ADDR_W-1:0]     wr_addr;
        logic [WORD_W-1:0]     addr_hi;
        logic [WORD_W-1:0]     addr_lo;
    } cmd_t;

    // One result beat, blocked in the lowest bit
    typedef struct packed {
        logic write_rejected;
        logic allow_hit;
        logic deny_hit;
        logic blocked;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WALK,
        ST_DONE
    } back_state_t;

endpackage

// ===== sv/cadf_front.sv =====
// Front end of the prefix filter: takes input beats and classifies them.
// Depends on cadf_pkg; feeds cadf_cmd_fifo.
module cadf_front
(
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cadf_pkg::S_TDATA_W-1:0]  s_tdata,   // list_select, rule_slot,
                                                        // addr_family, prefix_bits,
                                                        // addr_hi, addr_lo
    input  logic                            s_tuser,   // req_type
    input  logic                            q_full,
    output logic                            q_push,
    output cadf_pkg::cmd_t                  q_cmd
);

    logic                            list_select;
    logic [cadf_pkg::SLOT_W-1:0]     rule_slot;
    logic [cadf_pkg::FAM_W-1:0]      addr_family;
    logic [cadf_pkg::PREFIX_W-1:0]   prefix_bits;
    logic [cadf_pkg::WORD_W-1:0]     addr_hi;
    logic [cadf_pkg::WORD_W-1:0]     addr_lo;
    logic                            is_v4;
    logic                            is_v6;
    logic                            slot_ok;

    // Unpack the beat
    assign list_select = s_tdata[cadf_pkg::LIST_LSB];
    assign rule_slot   = s_tdata[cadf_pkg::SLOT_LSB +: cadf_pkg::SLOT_W];
    assign addr_family = s_tdata[cadf_pkg::FAM_LSB +: cadf_pkg::FAM_W];
    assign prefix_bits = s_tdata[cadf_pkg::PREFIX_LSB +: cadf_pkg::PREFIX_W];
    assign addr_hi     = s_tdata[cadf_pkg::HI_LSB +: cadf_pkg::WORD_W];
    assign addr_lo     = s_tdata[cadf_pkg::LO_LSB +: cadf_pkg::WORD_W];

    assign is_v4   = (addr_family == cadf_pkg::FAM_V4);
    assign is_v6   = (addr_family == cadf_pkg::FAM_V6);
    assign slot_ok = (int'(rule_slot) < cadf_pkg::RULES_PER_LIST);

    // Hold input while the queue is full
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // Classify the request and prepare its operands
    always_comb
    begin
        q_cmd.kind    = cadf_pkg::KIND_NULL;
        q_cmd.rule_ok = (is_v4 && (int'(prefix_bits) <= cadf_pkg::V4_PREFIX_MAX)) ||
                        (is_v6 && (int'(prefix_bits) <= cadf_pkg::V6_PREFIX_MAX));
        q_cmd.fam_bit = addr_family[0];
        q_cmd.prefix  = prefix_bits;
        q_cmd.addr_hi = addr_hi;
        q_cmd.addr_lo = addr_lo;
        if (list_select)
        begin
            q_cmd.wr_addr = cadf_pkg::ADDR_W'(cadf_pkg::RULES_PER_LIST)
                          + cadf_pkg::ADDR_W'(rule_slot);
        end
        else
        begin
            q_cmd.wr_addr = cadf_pkg::ADDR_W'(rule_slot);
        end

        case (s_tuser)
            cadf_pkg::REQ_WRITE:
            begin
                // A slot beyond the list drops the write
                if (slot_ok)
                begin
                    q_cmd.kind = cadf_pkg::KIND_WRITE;
                end
            end
            cadf_pkg::REQ_CHECK:
            begin
                // Unknown families always pass
                if (is_v4 || is_v6)
                begin
                    q_cmd.kind = cadf_pkg::KIND_CHECK;
                end
                // Only the top 32 bits take part for IPv4
                if (is_v4)
                begin
                    q_cmd.addr_hi = {addr_hi[cadf_pkg::WORD_W-1:32], 32'h0};
                    q_cmd.addr_lo = '0;
                end
            end
            default:
            begin
                q_cmd.kind = cadf_pkg::KIND_NULL;
            end
        endcase
    end

endmodule

// ===== sv/cadf_cmd_fifo.sv =====
// Short command queue between the front and back ends of the prefix filter.
// Depends on cadf_pkg for the command type and depth.
module cadf_cmd_fifo
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cadf_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            pop_valid,
    output cadf_pkg::cmd_t  pop_cmd
);

    cadf_pkg::cmd_t                   slot_reg [cadf_pkg::CMDQ_DEPTH];
    logic [cadf_pkg::CMDQ_PTR_W-1:0]  wr_ptr_reg;
    logic [cadf_pkg::CMDQ_PTR_W-1:0]  wr_ptr_next;
    logic [cadf_pkg::CMDQ_PTR_W-1:0]  rd_ptr_reg;
    logic [cadf_pkg::CMDQ_PTR_W-1:0]  rd_ptr_next;
    logic [cadf_pkg::CMDQ_CNT_W-1:0]  count_reg;
    logic [cadf_pkg::CMDQ_CNT_W-1:0]  count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full      = (count_reg == cadf_pkg::CMDQ_CNT_W'(cadf_pkg::CMDQ_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_cmd   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (int'(wr_ptr_reg) == cadf_pkg::CMDQ_DEPTH - 1) ? '0
                        : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (int'(rd_ptr_reg) == cadf_pkg::CMDQ_DEPTH - 1) ? '0
                        : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count_reg) <= cadf_pkg::CMDQ_DEPTH)
        else $error("command queue occupancy beyond depth");

endmodule

// ===== sv/cadf_back.sv =====
// Back end of the prefix filter: rule memory, list walk and result register.
// Depends on cadf_pkg; takes commands from cadf_cmd_fifo.
module cadf_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  cadf_pkg::cmd_t                    q_cmd,
    output logic                              q_pop,
    input  logic [cadf_pkg::CNT_W-1:0]        allow_count,
    input  logic [cadf_pkg::CNT_W-1:0]        deny_count,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [cadf_pkg::M_TDATA_W-1:0]    m_tdata   // blocked, deny_hit,
                                                        // allow_hit, write_rejected
);

    typedef struct packed {
        logic [cadf_pkg::PREFIX_W-1:0]  prefix;
        logic                           fam_bit;
        logic [cadf_pkg::WORD_W-1:0]    addr_hi;
        logic [cadf_pkg::WORD_W-1:0]    addr_lo;
    } rule_word_t;

    rule_word_t                     rule_mem [cadf_pkg::TOTAL_RULES];
    logic                           rule_valid_reg [cadf_pkg::TOTAL_RULES];
    rule_word_t                     rd_word_reg;

    cadf_pkg::back_state_t          state_reg;
    cadf_pkg::back_state_t          state_next;
    logic [cadf_pkg::WALK_W-1:0]    walk_idx_reg;
    logic [cadf_pkg::WALK_W-1:0]    walk_idx_next;
    logic                           deny_hit_reg;
    logic                           deny_hit_next;
    logic                           allow_hit_reg;
    logic                           allow_hit_next;
    logic                           rd_live_reg;
    logic                           rd_live_next;
    logic                           rd_deny_reg;
    logic                           rd_deny_next;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    cadf_pkg::result_t              out_data_reg;
    cadf_pkg::result_t              out_data_next;
    logic [cadf_pkg::WORD_W-1:0]    chk_hi_reg;
    logic [cadf_pkg::WORD_W-1:0]    chk_lo_reg;
    logic                           chk_fam_reg;

    logic                           out_free;
    logic                           issue;
    logic                           is_deny;
    logic [cadf_pkg::WALK_W-1:0]    walk_slot;
    logic [cadf_pkg::CNT_W-1:0]     walk_count;
    logic                           in_use;
    logic [cadf_pkg::ADDR_W-1:0]    rd_addr;
    logic                           mem_we;
    logic                           latch_check;
    logic [cadf_pkg::WORD_W-1:0]    mask_hi;
    logic [cadf_pkg::WORD_W-1:0]    mask_lo;
    logic                           rule_hit;

    // Leading-ones mask over the upper address word
    function automatic logic [cadf_pkg::WORD_W-1:0] prefix_mask_hi(
        input logic [cadf_pkg::PREFIX_W-1:0] p);
        logic [6:0] sh;
        begin
            sh = 7'd64 - {1'b0, p[5:0]};
            if (p == '0)
            begin
                prefix_mask_hi = '0;
            end
            else if (p >= 8'd64)
            begin
                prefix_mask_hi = '1;
            end
            else
            begin
                prefix_mask_hi = {cadf_pkg::WORD_W{1'b1}} << sh;
            end
        end
    endfunction

    // Leading-ones mask over the lower address word
    function automatic logic [cadf_pkg::WORD_W-1:0] prefix_mask_lo(
        input logic [cadf_pkg::PREFIX_W-1:0] p);
        logic [7:0] sh;
        begin
            sh = 8'd128 - p;
            if (p <= 8'd64)
            begin
                prefix_mask_lo = '0;
            end
            else if (p >= 8'd128)
            begin
                prefix_mask_lo = '1;
            end
            else
            begin
                prefix_mask_lo = {cadf_pkg::WORD_W{1'b1}} << sh[6:0];
            end
        end
    endfunction

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = cadf_pkg::M_TDATA_W'(out_data_reg);

    // Decide which slot the walk reads this cycle and whether it is in use
    assign issue      = (state_reg == cadf_pkg::ST_WALK) &&
                        (walk_idx_reg < cadf_pkg::WALK_W'(cadf_pkg::TOTAL_RULES));
    assign is_deny    = (walk_idx_reg >= cadf_pkg::WALK_W'(cadf_pkg::RULES_PER_LIST));
    assign walk_slot  = is_deny ? walk_idx_reg - cadf_pkg::WALK_W'(cadf_pkg::RULES_PER_LIST)
                                : walk_idx_reg;
    assign walk_count = is_deny ? deny_count : allow_count;
    assign in_use     = {cadf_pkg::CNT_W'(0), walk_slot} < {cadf_pkg::WALK_W'(0), walk_count};
    assign rd_addr    = walk_idx_reg[cadf_pkg::ADDR_W-1:0];

    // Compare the rule read last cycle against the checked address
    assign mask_hi  = prefix_mask_hi(rd_word_reg.prefix);
    assign mask_lo  = prefix_mask_lo(rd_word_reg.prefix);
    assign rule_hit = rd_live_reg && (rd_word_reg.fam_bit == chk_fam_reg) &&
                      (((chk_hi_reg ^ rd_word_reg.addr_hi) & mask_hi) == '0) &&
                      (((chk_lo_reg ^ rd_word_reg.addr_lo) & mask_lo) == '0);

    // Sequence commands: store, walk, report
    always_comb
    begin
        state_next     = state_reg;
        walk_idx_next  = walk_idx_reg;
        deny_hit_next  = deny_hit_reg;
        allow_hit_next = allow_hit_reg;
        rd_live_next   = issue && in_use && rule_valid_reg[rd_addr];
        rd_deny_next   = is_deny;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        latch_check    = 1'b0;

        if (rule_hit)
        begin
            if (rd_deny_reg)
            begin
                deny_hit_next = 1'b1;
            end
            else
            begin
                allow_hit_next = 1'b1;
            end
        end

        case (state_reg)
            cadf_pkg::ST_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    case (q_cmd.kind)
                        cadf_pkg::KIND_WRITE:
                        begin
                            mem_we         = 1'b1;
                            out_valid_next = 1'b1;
                            out_data_next  = '{write_rejected: !q_cmd.rule_ok,
                                               allow_hit: 1'b0, deny_hit: 1'b0,
                                               blocked: 1'b0};
                        end
                        cadf_pkg::KIND_CHECK:
                        begin
                            latch_check    = 1'b1;
                            walk_idx_next  = '0;
                            deny_hit_next  = 1'b0;
                            allow_hit_next = 1'b0;
                            state_next     = cadf_pkg::ST_WALK;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_data_next  = '0;
                        end
                    endcase
                end
            end
            cadf_pkg::ST_WALK:
            begin
                if (issue)
                begin
                    walk_idx_next = walk_idx_reg + 1'b1;
                end
                else
                begin
                    state_next = cadf_pkg::ST_DONE;
                end
            end
            cadf_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = '{write_rejected: 1'b0,
                                       allow_hit: allow_hit_reg,
                                       deny_hit: deny_hit_reg,
                                       blocked: deny_hit_reg ||
                                                ((allow_count != '0) && !allow_hit_reg)};
                    state_next     = cadf_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cadf_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cadf_pkg::ST_IDLE;
            walk_idx_reg  <= '0;
            deny_hit_reg  <= 1'b0;
            allow_hit_reg <= 1'b0;
            rd_live_reg   <= 1'b0;
            rd_deny_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            walk_idx_reg  <= walk_idx_next;
            deny_hit_reg  <= deny_hit_next;
            allow_hit_reg <= allow_hit_next;
            rd_live_reg   <= rd_live_next;
            rd_deny_reg   <= rd_deny_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Rule valid bits, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < cadf_pkg::TOTAL_RULES; k++)
            begin
                rule_valid_reg[k] <= 1'b0;
            end
        end
        else if (mem_we)
        begin
            rule_valid_reg[q_cmd.wr_addr] <= q_cmd.rule_ok;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (latch_check)
        begin
            chk_hi_reg  <= q_cmd.addr_hi;
            chk_lo_reg  <= q_cmd.addr_lo;
            chk_fam_reg <= q_cmd.fam_bit;
        end
    end

    // Rule memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            rule_mem[q_cmd.wr_addr] <= '{prefix: q_cmd.prefix, fam_bit: q_cmd.fam_bit,
                                         addr_hi: q_cmd.addr_hi, addr_lo: q_cmd.addr_lo};
        end
        if (issue)
        begin
            rd_word_reg <= rule_mem[rd_addr];
        end
    end

    a_live_from_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_live_reg |-> $past(state_reg == cadf_pkg::ST_WALK))
        else $error("rule compare outside a list walk");

    a_done_reports: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cadf_pkg::ST_DONE && out_free)
        |=> (state_reg == cadf_pkg::ST_IDLE && out_valid_reg))
        else $error("finished check did not load a result");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == cadf_pkg::ST_WALK)
        |-> (walk_idx_reg <= cadf_pkg::WALK_W'(cadf_pkg::TOTAL_RULES)))
        else $error("walk index ran past the rule memory");

endmodule

// ===== sv/cidr_allow_deny_filter_core.sv =====
// Top level of the allow/deny prefix filter: configuration registers and wiring.
// Depends on cadf_pkg, cadf_front, cadf_cmd_fifo and cadf_back.
//
// Each input beat is a rule write or an address check and gives exactly one
// output beat. With the back end idle, a rule write, and a check of an unknown
// family, raises m_tvalid once its command has passed through the queue and the
// output register. A check walks both rule lists through the read port of the
// rule memory one slot per cycle, then loads its result into the output
// register; the back end handles one command at a time while the front end
// keeps filling a two-deep queue. A result stays in the output register until
// taken. The user must write the allow and deny counts through the
// configuration channel only while no beat is in flight; the block does not
// enforce this. Counts above the list size cover the whole list.
module cidr_allow_deny_filter_core
(
    input  logic                            clk,
    input  logic                            rst_n,
    // Input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cadf_pkg::S_TDATA_W-1:0]  s_tdata,   // list_select, rule_slot,
                                                        // addr_family, prefix_bits,
                                                        // addr_hi, addr_lo, zero pad
    input  logic                            s_tuser,   // req_type
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cadf_pkg::M_TDATA_W-1:0]  m_tdata,   // blocked, deny_hit,
                                                        // allow_hit, write_rejected,
                                                        // zero pad
    // Configuration writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic                            cfg_index,
    input  logic [cadf_pkg::CNT_W-1:0]      cfg_data
);

    logic [cadf_pkg::CNT_W-1:0]  allow_count_reg;
    logic [cadf_pkg::CNT_W-1:0]  allow_count_next;
    logic [cadf_pkg::CNT_W-1:0]  deny_count_reg;
    logic [cadf_pkg::CNT_W-1:0]  deny_count_next;

    logic                        q_push;
    logic                        q_full;
    logic                        q_pop;
    logic                        q_valid;
    cadf_pkg::cmd_t              push_cmd;
    cadf_pkg::cmd_t              pop_cmd;

    assign cfg_ready = 1'b1;

    // Decode configuration writes
    always_comb
    begin
        allow_count_next = allow_count_reg;
        deny_count_next  = deny_count_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                cadf_pkg::CFG_ALLOW_COUNT: allow_count_next = cfg_data;
                cadf_pkg::CFG_DENY_COUNT:  deny_count_next  = cfg_data;
                default:
                begin
                    allow_count_next = allow_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            allow_count_reg <= '0;
            deny_count_reg  <= '0;
        end
        else
        begin
            allow_count_reg <= allow_count_next;
            deny_count_reg  <= deny_count_next;
        end
    end

    cadf_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (push_cmd)
    );

    cadf_cmd_fifo u_cmd_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (pop_cmd)
    );

    cadf_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_cmd       (pop_cmd),
        .q_pop       (q_pop),
        .allow_count (allow_count_reg),
        .deny_count  (deny_count_reg),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
